// ===== design/bqlp_pkg.sv =====
// ---------------------------------------------------------------------------
// bqlp_pkg: shared constants and tables for the low-pass biquad
// Widths, fixed-point formats and the quarter-wave sine table used by the
// per-sample coefficient biquad.
// ---------------------------------------------------------------------------
package bqlp_pkg;

  // field widths
  localparam int SAMPLE_W   = 24;
  localparam int CUT_W      = 16;
  localparam int QUAL_W     = 18;
  localparam int CFG_W      = 18;
  localparam logic [CFG_W-1:0] SR_RESET = CFG_W'(48000);
  localparam logic [QUAL_W-1:0] Q_FLOOR = QUAL_W'(41);

  // fixed-point formats
  localparam int COEFF_FRAC = 28;
  localparam int COEF_W     = 32;
  localparam int TRIG_W     = COEFF_FRAC + 1;
  localparam int ALPHA_SHIFT = 11;

  // quarter-wave table
  localparam int SIN_DEPTH = 1024;
  localparam int SIN_AW    = $clog2(SIN_DEPTH + 1);
  localparam int QTR_W     = $clog2(SIN_DEPTH);
  localparam int PHASE_W   = QTR_W + 2;
  localparam int PH_SHIFT  = PHASE_W + 1;
  localparam int SIN_DIV_SH = $clog2(2 * SIN_DEPTH);

  // shared divider sizes
  localparam int NUM_W     = TRIG_W + ALPHA_SHIFT;
  localparam int NUMREG_W  = NUM_W + COEFF_FRAC + 1;
  localparam int DEN_W     = 37;
  localparam int REM_W     = DEN_W;
  localparam int QUO_W     = 42;
  localparam int CNT_W     = $clog2(NUMREG_W + 1);
  localparam int PH_DIV_W  = CFG_W + PH_SHIFT + 1;

  // filter sum
  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [TRIG_W-1:0] sin_tab_t [SIN_DEPTH+1];

  // shift-subtract quotient, used only while the table is built
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | 64'(a[i]);
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // sin(k*pi/(2*depth)) by a q30 taylor series, clamped and rounded
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint sum;
    int sh;
    sh = 30 - COEFF_FRAC;
    for (int k = 0; k <= SIN_DEPTH; k++) begin
      x = (longint'(k) * HALF_PI_Q30 * 2 + SIN_DEPTH) >> SIN_DIV_SH;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x2 + (64'd1 << 29)) >> 30;
        term = udiv64(term, 64'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      v = longint'(sum);
      if (sh != 0) v = (v + (64'd1 << (sh - 1))) >> sh;
      tab[k] = v[TRIG_W-1:0];
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// ===== design/biquad_lowpass_per_sample_coeff.sv =====
// ---------------------------------------------------------------------------
// biquad_lowpass_per_sample_coeff: resonant low-pass biquad
// Recomputes cookbook low-pass coefficients for every sample on one shared
// restoring divider and one multiplier, then runs the direct-form-I recursion.
// ---------------------------------------------------------------------------
//
//  channel | signals                                       | dir
//  --------+-----------------------------------------------+-----
//  cfg     | cfg_valid_i cfg_ready_o cfg_sample_rate_i     | in
//  in      | in_valid_i in_ready_o in_sample_i cutoff_hz_i | in
//          | quality_i                                     |
//  out     | out_valid_o out_ready_i out_sample_o clipped_o| out
//
// An item passes through a 16-bit modulo, a 32-bit phase and a 40-bit alpha
// division (the first two are skipped at a zero sample rate), the table reads,
// a division for each of four coefficients, the multiply-accumulate and the
// output load; the next item is taken once the block is back in idle.
// Reset clears the delay line and sets the sample rate to 48000.
// Input is not ready while an item is at work; a result waits in the output
// register and the next item stalls in its last cycle until that is taken.

module biquad_lowpass_per_sample_coeff (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bqlp_pkg::CFG_W-1:0]          cfg_sample_rate_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [bqlp_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic [bqlp_pkg::CUT_W-1:0]          cutoff_hz_i,
  input  logic [bqlp_pkg::QUAL_W-1:0]         quality_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bqlp_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic                                clipped_o
);
  import bqlp_pkg::*;

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MOD   = 4'd1;
  localparam logic [3:0] ST_PHASE = 4'd2;
  localparam logic [3:0] ST_ROM0  = 4'd3;
  localparam logic [3:0] ST_ROM1  = 4'd4;
  localparam logic [3:0] ST_ROM2  = 4'd5;
  localparam logic [3:0] ST_ALPHA = 4'd6;
  localparam logic [3:0] ST_PREP  = 4'd7;
  localparam logic [3:0] ST_NORM  = 4'd8;
  localparam logic [3:0] ST_CONV  = 4'd9;
  localparam logic [3:0] ST_MAC   = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  // coefficient slots
  localparam logic [1:0] OP_B0 = 2'd0;
  localparam logic [1:0] OP_B1 = 2'd1;
  localparam logic [1:0] OP_A1 = 2'd2;
  localparam logic [1:0] OP_A2 = 2'd3;

  localparam int MAC_TERMS = 5;
  localparam logic [CNT_W-1:0] STEPS_MOD   = CNT_W'(CUT_W);
  localparam logic [CNT_W-1:0] STEPS_PHASE = CNT_W'(PH_DIV_W);
  localparam logic [CNT_W-1:0] STEPS_ALPHA = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] STEPS_NORM  = CNT_W'(NUMREG_W);
  localparam logic [QUO_W-1:0] QUO_LIM = QUO_W'(1) << 40;
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [QUO_W-1:0] QR_POS_LIM = QUO_W'(COEF_MAX);
  localparam logic [QUO_W-1:0] QR_NEG_LIM = QUO_W'(1) << (COEF_W - 1);
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [DEN_W-1:0] ONE_A = DEN_W'(1) << COEFF_FRAC;
  localparam logic signed [NUM_W:0] ONE_N = (NUM_W+1)'(1) << COEFF_FRAC;
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (COEFF_FRAC - 1);

  // registers
  logic [3:0]                  state_q, state_d;
  logic [CFG_W-1:0]            sr_q, sr_d;
  logic signed [SAMPLE_W-1:0]  x_q, x_d, x1_q, x1_d, x2_q, x2_d;
  logic signed [SAMPLE_W-1:0]  y1_q, y1_d, y2_q, y2_d;
  logic [QUAL_W-1:0]           qf_q, qf_d;
  logic [NUMREG_W-1:0]         num_q, num_d;
  logic [DEN_W-1:0]            den_q, den_d;
  logic [REM_W-1:0]            rem_q, rem_d;
  logic [QUO_W-1:0]            quo_q, quo_d;
  logic                        big_q, big_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [PHASE_W-1:0]          p_q, p_d;
  logic [TRIG_W-1:0]           tr_q, tr_d, rom_q;
  logic                        s_neg_q, s_neg_d;
  logic signed [TRIG_W:0]      c_q, c_d;
  logic signed [DEN_W-2:0]     alpha_q, alpha_d;
  logic [1:0]                  op_q, op_d;
  logic                        neg_q, neg_d;
  logic signed [COEF_W-1:0]    coef_q [4];
  logic signed [COEF_W-1:0]    coef_d [4];
  logic [2:0]                  mac_cnt_q, mac_cnt_d;
  logic signed [PROD_W-1:0]    prod_q, prod_d;
  logic signed [ACC_W-1:0]     acc_q, acc_d;
  logic signed [SAMPLE_W-1:0]  out_sample_q, out_sample_d;
  logic                        clipped_q, clipped_d;
  logic                        out_valid_q, out_valid_d;

  // combinational helpers
  logic [REM_W:0]              rem_sh;
  logic [REM_W:0]              den_ext;
  logic                        ge;
  logic [REM_W-1:0]            rem_nx;
  logic [QUO_W-1:0]            quo_sh, quo_nx;
  logic                        big_nx;
  logic                        last;
  logic [SIN_AW-1:0]           rom_addr;
  logic [PH_DIV_W-1:0]         ph_div;
  logic signed [TRIG_W:0]      tr_s, tdr_s, c_sel;
  logic [TRIG_W-1:0]           s_mag;
  logic signed [DEN_W-1:0]     a0;
  logic signed [DEN_W:0]       den_s, den_abs;
  logic signed [NUM_W:0]       num_s, num_abs;
  logic [DEN_W-1:0]            d_mag;
  logic [QUO_W:0]              qr_sum;
  logic [QUO_W-1:0]            qr;
  logic signed [COEF_W-1:0]    coef_new;
  logic signed [COEF_W-1:0]    coef_sel;
  logic signed [SAMPLE_W-1:0]  smp_sel;
  logic signed [ACC_W-1:0]     y_full;
  logic                        in_acc, out_free;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign clipped_o    = clipped_q;

  // one restoring divide step, quotient clamped and overflow kept sticky
  always_comb begin
    rem_sh  = {rem_q, num_q[NUMREG_W-1]};
    den_ext = {1'b0, den_q};
    ge      = (rem_sh >= den_ext);
    rem_nx  = ge ? REM_W'(rem_sh - den_ext) : REM_W'(rem_sh);
    quo_sh  = {quo_q[QUO_W-2:0], ge};
    big_nx  = big_q || (quo_sh > QUO_LIM);
    quo_nx  = (quo_sh > QUO_LIM) ? QUO_LIM : quo_sh;
    last    = (cnt_q == CNT_W'(1));
  end

  // quarter-wave table, registered read
  always_comb begin
    if (state_q == ST_ROM0) begin
      rom_addr = {1'b0, p_q[QTR_W-1:0]};
    end else begin
      rom_addr = SIN_AW'(SIN_DEPTH) - {1'b0, p_q[QTR_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SIN_TAB[rom_addr];
  end

  // phase dividend, sine and cosine by quadrant
  always_comb begin
    ph_div = {rem_nx[CFG_W-1:0], {PH_SHIFT{1'b0}}} + PH_DIV_W'(sr_q);
    tr_s   = {1'b0, tr_q};
    tdr_s  = {1'b0, rom_q};
    s_mag  = p_q[QTR_W] ? rom_q : tr_q;
    case (p_q[PHASE_W-1:QTR_W])
      2'd0:    c_sel = tdr_s;
      2'd1:    c_sel = -tr_s;
      2'd2:    c_sel = -tdr_s;
      default: c_sel = tr_s;
    endcase
  end

  // numerator and divisor of the coefficient being formed
  always_comb begin
    a0 = ONE_A + DEN_W'(alpha_q);
    if (op_q == OP_B0) den_s = {a0, 1'b0};
    else den_s = (DEN_W+1)'(a0);
    case (op_q) inside
      OP_B0, OP_B1: num_s = ONE_N - (NUM_W+1)'(c_q);
      OP_A1:        num_s = (NUM_W+1)'(c_q) <<< 1;
      default:      num_s = (NUM_W+1)'(alpha_q) - ONE_N;
    endcase
    num_abs = num_s[NUM_W] ? -num_s : num_s;
    den_abs = den_s[DEN_W] ? -den_s : den_s;
    d_mag   = (den_abs == '0) ? DEN_W'(1) : den_abs[DEN_W-1:0];
  end

  // rounding and saturation of a finished quotient
  always_comb begin
    qr_sum = {1'b0, quo_q} + (QUO_W+1)'(1);
    qr     = qr_sum[QUO_W:1];
    if (neg_q) begin
      coef_new = (big_q || (qr > QR_NEG_LIM)) ? COEF_MIN : -COEF_W'(qr);
    end else begin
      coef_new = (big_q || (qr > QR_POS_LIM)) ? COEF_MAX : COEF_W'(qr);
    end
  end

  // tap selection for the multiply-accumulate
  always_comb begin
    case (mac_cnt_q)
      3'd0:    begin coef_sel = coef_q[OP_B0]; smp_sel = x_q;  end
      3'd1:    begin coef_sel = coef_q[OP_B1]; smp_sel = x1_q; end
      3'd2:    begin coef_sel = coef_q[OP_B0]; smp_sel = x2_q; end
      3'd3:    begin coef_sel = coef_q[OP_A1]; smp_sel = y1_q; end
      default: begin coef_sel = coef_q[OP_A2]; smp_sel = y2_q; end
    endcase
    y_full = (acc_q + ACC_HALF) >>> COEFF_FRAC;
  end

  // sequencer and datapath next state
  always_comb begin
    state_d      = state_q;
    sr_d         = sr_q;
    x_d          = x_q;
    x1_d         = x1_q;
    x2_d         = x2_q;
    y1_d         = y1_q;
    y2_d         = y2_q;
    qf_d         = qf_q;
    num_d        = num_q;
    den_d        = den_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    big_d        = big_q;
    cnt_d        = cnt_q;
    p_d          = p_q;
    tr_d         = tr_q;
    s_neg_d      = s_neg_q;
    c_d          = c_q;
    alpha_d      = alpha_q;
    op_d         = op_q;
    neg_d        = neg_q;
    coef_d       = coef_q;
    mac_cnt_d    = mac_cnt_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    out_sample_d = out_sample_q;
    clipped_d    = clipped_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (cfg_valid_i) sr_d = cfg_sample_rate_i;

    // divider advances one bit in every divide state
    if ((state_q == ST_MOD) || (state_q == ST_PHASE) ||
        (state_q == ST_ALPHA) || (state_q == ST_NORM)) begin
      num_d = num_q << 1;
      rem_d = rem_nx;
      quo_d = quo_nx;
      big_d = big_nx;
      cnt_d = cnt_q - CNT_W'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_d   = in_sample_i;
          qf_d  = (quality_i < Q_FLOOR) ? Q_FLOOR : quality_i;
          num_d = {cutoff_hz_i, {(NUMREG_W-CUT_W){1'b0}}};
          den_d = DEN_W'(sr_q);
          rem_d = '0;
          quo_d = '0;
          big_d = 1'b0;
          cnt_d = STEPS_MOD;
          if (sr_q == '0) begin
            p_d     = '0;
            state_d = ST_ROM0;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        // remainder is cutoff modulo rate; start the phase division
        if (last) begin
          num_d   = {ph_div, {(NUMREG_W-PH_DIV_W){1'b0}}};
          den_d   = DEN_W'({sr_q, 1'b0});
          rem_d   = '0;
          quo_d   = '0;
          big_d   = 1'b0;
          cnt_d   = STEPS_PHASE;
          state_d = ST_PHASE;
        end
      end
      ST_PHASE: begin
        // a full turn has only bit 12 set, so the low bits wrap it to zero
        if (last) begin
          p_d     = quo_nx[PHASE_W-1:0];
          state_d = ST_ROM0;
        end
      end
      ST_ROM0: state_d = ST_ROM1;
      ST_ROM1: begin
        tr_d    = rom_q;
        state_d = ST_ROM2;
      end
      ST_ROM2: begin
        c_d     = c_sel;
        s_neg_d = p_q[PHASE_W-1];
        num_d   = {s_mag, {ALPHA_SHIFT{1'b0}}, {(NUMREG_W-NUM_W){1'b0}}};
        den_d   = DEN_W'(qf_q);
        rem_d   = '0;
        quo_d   = '0;
        big_d   = 1'b0;
        cnt_d   = STEPS_ALPHA;
        state_d = ST_ALPHA;
      end
      ST_ALPHA: begin
        if (last) begin
          alpha_d = s_neg_q ? -(DEN_W-1)'(quo_nx) : (DEN_W-1)'(quo_nx);
          op_d    = OP_B0;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        num_d   = {num_abs[NUM_W-1:0], {(NUMREG_W-NUM_W){1'b0}}};
        den_d   = d_mag;
        neg_d   = num_s[NUM_W] ^ den_s[DEN_W];
        rem_d   = '0;
        quo_d   = '0;
        big_d   = 1'b0;
        cnt_d   = STEPS_NORM;
        state_d = ST_NORM;
      end
      ST_NORM: begin
        if (last) state_d = ST_CONV;
      end
      ST_CONV: begin
        coef_d[op_q] = coef_new;
        if (op_q == OP_A2) begin
          mac_cnt_d = '0;
          state_d   = ST_MAC;
        end else begin
          op_d    = op_q + 2'd1;
          state_d = ST_PREP;
        end
      end
      ST_MAC: begin
        // product registered, summed in the following cycle
        if (mac_cnt_q < 3'(MAC_TERMS)) prod_d = coef_sel * smp_sel;
        if (mac_cnt_q == '0) acc_d = '0;
        else acc_d = acc_q + ACC_W'(prod_q);
        if (mac_cnt_q == 3'(MAC_TERMS)) state_d = ST_FIN;
        else mac_cnt_d = mac_cnt_q + 3'd1;
      end
      ST_FIN: begin
        if (out_free) begin
          if (y_full > ACC_W'(SMP_MAX)) begin
            out_sample_d = SMP_MAX;
            clipped_d    = 1'b1;
          end else if (y_full < ACC_W'(SMP_MIN)) begin
            out_sample_d = SMP_MIN;
            clipped_d    = 1'b1;
          end else begin
            out_sample_d = y_full[SAMPLE_W-1:0];
            clipped_d    = 1'b0;
          end
          out_valid_d = 1'b1;
          x2_d        = x1_q;
          x1_d        = x_q;
          y2_d        = y1_q;
          y1_d        = out_sample_d;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state and delay line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sr_q        <= SR_RESET;
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      op_q        <= OP_B0;
      mac_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      sr_q        <= sr_d;
      x1_q        <= x1_d;
      x2_q        <= x2_d;
      y1_q        <= y1_d;
      y2_q        <= y2_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      op_q        <= op_d;
      mac_cnt_q   <= mac_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    qf_q         <= qf_d;
    num_q        <= num_d;
    den_q        <= den_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    big_q        <= big_d;
    p_q          <= p_d;
    tr_q         <= tr_d;
    s_neg_q      <= s_neg_d;
    c_q          <= c_d;
    alpha_q      <= alpha_d;
    neg_q        <= neg_d;
    coef_q       <= coef_d;
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    out_sample_q <= out_sample_d;
    clipped_q    <= clipped_d;
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken while an item is at work");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MOD) || (state_q == ST_PHASE) || (state_q == ST_ALPHA) ||
     (state_q == ST_NORM)) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> ((out_sample_o == SMP_MAX) || (out_sample_o == SMP_MIN)))
    else $error("clip flag without a saturated sample");

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the per-sample low-pass biquad
// Drives audio items with random cutoff and Q through the in channel, predicts
// every filtered sample with an independent fixed-point model of the filter
// and compares each output item in order. The sample rate register is swept
// over several settings, zero and the extremes among them.
// ---------------------------------------------------------------------------
module tb_top;
  import bqlp_pkg::*;

  localparam int DEPTH     = SIN_DEPTH;
  localparam int FRAC      = COEFF_FRAC;
  localparam int DRAIN_CYC = 450;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic [CUT_W-1:0]           cut;
    logic [QUAL_W-1:0]          qual;
  } audio_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       clip;
  } filt_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_rate = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_smp = '0;
  logic [CUT_W-1:0] in_cut = '0;
  logic [QUAL_W-1:0] in_qual = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_smp;
  logic clip;

  // model of the block
  longint sine_q [0:DEPTH];
  longint rate_m = 48000;
  longint x1_m = 0, x2_m = 0, y1_m = 0, y2_m = 0;

  audio_item_t pending_items [$];
  filt_out_t   filtered_q [$];
  int err_count = 0;
  int n_accepted = 0;
  bit in_took = 1'b0;

  biquad_lowpass_per_sample_coeff i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_sample_rate_i (cfg_rate),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .in_sample_i       (in_smp),
    .cutoff_hz_i       (in_cut),
    .quality_i         (in_qual),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_sample_o      (out_smp),
    .clipped_o         (clip)
  );

  // clock and reset
  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // quarter-wave sine in q30 by taylor series, rounded to the coefficient format
  function automatic void fill_sine();
    longint unsigned x, x2, term, v;
    longint sum;
    for (int k = 0; k <= DEPTH; k++) begin
      x = (longint'(k) * 64'd1686629713 * 2 + DEPTH) / (2 * DEPTH);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x2 + (64'd1 << 29)) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      v = longint'(sum);
      v = (v + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      sine_q[k] = longint'(v);
    end
  endfunction

  // num * 2^frac / den, rounded half away from zero, saturated to 32 bits
  function automatic longint coef_div(longint num, longint den);
    bit neg, big, b;
    longint unsigned n, d, rem, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? longint'(-num) : num;
    d = (den < 0) ? longint'(-den) : den;
    rem = 0;
    q = 0;
    big = 1'b0;
    if (d == 0) begin
      d = 1;
      neg = num < 0;
    end
    for (int i = 40 + FRAC; i >= 0; i--) begin
      b = (i > FRAC) ? n[i - FRAC - 1] : 1'b0;
      rem = (rem << 1) | b;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 1;
      end
      if (q > (64'd1 << 40)) begin
        q = 64'd1 << 40;
        big = 1'b1;
      end
    end
    q = (q + 1) >> 1;
    if (neg) begin
      if (big || q > 64'd2147483648) return -64'sd2147483648;
      return -longint'(q);
    end
    if (big || q > 64'd2147483647) return 64'sd2147483647;
    return longint'(q);
  endfunction

  // coefficients for this item, then one step of the direct-form-i recursion
  function automatic filt_out_t predict_biquad(audio_item_t it);
    filt_out_t r;
    longint unsigned p, f, rr, hi, lo, u;
    longint s, c, qf, alpha, a0, y, one;
    longint coef [5];
    longint hist [5];
    int quad;
    one = 64'sd1 <<< FRAC;
    f = it.cut;
    p = 0;
    if (rate_m != 0) begin
      p = ((f % rate_m) * 2 * (4 * DEPTH) + rate_m) / (2 * rate_m);
      if (p >= 4 * DEPTH) p = p - 4 * DEPTH;
    end
    quad = int'(p / DEPTH);
    rr = p % DEPTH;
    case (quad)
      0: begin s = sine_q[rr]; c = sine_q[DEPTH - rr]; end
      1: begin s = sine_q[DEPTH - rr]; c = -sine_q[rr]; end
      2: begin s = -sine_q[rr]; c = -sine_q[DEPTH - rr]; end
      default: begin s = -sine_q[DEPTH - rr]; c = sine_q[rr]; end
    endcase
    qf = it.qual;
    if (qf < 41) qf = 41;
    alpha = (s * 2048) / qf;
    a0 = one + alpha;
    coef[1] = coef_div(one - c, a0);
    coef[0] = coef_div(one - c, 2 * a0);
    coef[2] = coef[0];
    coef[3] = coef_div(2 * c, a0);
    coef[4] = coef_div(alpha - one, a0);
    hist[0] = it.smp;
    hist[1] = x1_m;
    hist[2] = x2_m;
    hist[3] = y1_m;
    hist[4] = y2_m;
    hi = 0;
    lo = 0;
    for (int i = 0; i < 5; i++) begin
      u = longint'(coef[i] * hist[i]) + (64'd1 << 62);
      hi = hi + (u >> FRAC);
      lo = lo + (u & ((64'd1 << FRAC) - 1));
    end
    hi = hi + ((lo + (64'd1 << (FRAC - 1))) >> FRAC);
    y = longint'(hi) - longint'(64'd5 << (62 - FRAC));
    r.clip = 1'b0;
    if (y > 8388607) begin y = 8388607; r.clip = 1'b1; end
    if (y < -8388608) begin y = -8388608; r.clip = 1'b1; end
    x2_m = x1_m;
    x1_m = it.smp;
    y2_m = y1_m;
    y1_m = y;
    r.smp = y[SAMPLE_W-1:0];
    return r;
  endfunction

  // prediction on accepted items, config tracking and output checking
  always @(posedge clk) begin
    filt_out_t e;
    audio_item_t it;
    in_took <= in_valid && in_ready;
    if (cfg_valid && cfg_ready) rate_m = cfg_rate;
    if (in_valid && in_ready) begin
      it.smp = in_smp;
      it.cut = in_cut;
      it.qual = in_qual;
      filtered_q.push_back(predict_biquad(it));
      n_accepted++;
    end
    if (out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected output item: %0d clip %0b", out_smp, clip);
      end else begin
        e = filtered_q.pop_front();
        if (e.smp !== out_smp || e.clip !== clip) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected %0d clip %0b, got %0d clip %0b",
                     e.smp, e.clip, out_smp, clip);
        end
      end
    end
  end

  // input driver: bursts of items separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    audio_item_t it;
    if (in_valid && !in_took) begin
      // hold the offered item
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (rst_n && pending_items.size() > 0) begin
      it = pending_items.pop_front();
      in_smp <= it.smp;
      in_cut <= it.cut;
      in_qual <= it.qual;
      in_valid <= 1'b1;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output receiver: stall pattern redrawn from three modes at random, one long hold-off
  int rx_cyc = 0;
  int rx_mode = 0;
  int long_hold = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    rx_cyc++;
    if (rx_cyc % 256 == 0) rx_mode = $urandom_range(0, 2);
    if (!hold_done && n_accepted == 200) begin
      long_hold = 3000;
      hold_done = 1'b1;
    end
    if (long_hold > 0) begin
      long_hold--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (rx_cyc % 7) >= 3;
      endcase
    end
  end

  function automatic audio_item_t mk(int smp, int cut, int qual);
    audio_item_t it;
    it.smp = SAMPLE_W'(smp);
    it.cut = CUT_W'(cut);
    it.qual = QUAL_W'(qual);
    return it;
  endfunction

  function automatic audio_item_t rand_item();
    audio_item_t it;
    it.smp = SAMPLE_W'($urandom());
    case ($urandom_range(0, 3))
      0: it.cut = CUT_W'($urandom_range(0, 2000));
      default: it.cut = CUT_W'($urandom());
    endcase
    case ($urandom_range(0, 4))
      0: it.qual = QUAL_W'($urandom_range(0, 100));
      1: it.qual = QUAL_W'($urandom_range(2000, 4000));
      2: it.qual = QUAL_W'($urandom_range(40000, 262143));
      default: it.qual = QUAL_W'($urandom());
    endcase
    if ($urandom_range(0, 9) == 0)
      it.smp = ($urandom_range(0, 1) != 0) ? SAMPLE_W'(8388607) : SAMPLE_W'(-8388608);
    return it;
  endfunction

  // wait until nothing is in flight
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || filtered_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_rate(int rate);
    wait_idle();
    @(negedge clk);
    cfg_rate = CFG_W'(rate);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stimulus sequence
  initial begin
    int rates [7] = '{192000, 8000, 0, 262143, 1, 44100, 96000};
    fill_sine();
    @(posedge rst_n);
    // directed: field extremes, q floor, quadrants, wrap and clipping
    pending_items.push_back(mk(8388607, 0, 0));
    pending_items.push_back(mk(-8388608, 65535, 262143));
    pending_items.push_back(mk(1, 1000, 40));
    pending_items.push_back(mk(-1, 1000, 41));
    pending_items.push_back(mk(0, 12000, 2896));
    pending_items.push_back(mk(4000000, 24000, 2896));
    pending_items.push_back(mk(-4000000, 36000, 4096));
    pending_items.push_back(mk(123456, 48000, 4096));
    pending_items.push_back(mk(-123456, 50000, 1));
    for (int i = 0; i < 10; i++)
      pending_items.push_back(mk((i % 2) ? -8388608 : 8388607, 3000, 262143));
    pending_items.push_back(mk(0, 0, 262143));
    for (int i = 0; i < 300; i++) pending_items.push_back(rand_item());
    foreach (rates[k]) begin
      write_rate(rates[k]);
      pending_items.push_back(mk(8388607, rates[k] % 65536, 41));
      pending_items.push_back(mk(-8388608, (rates[k] / 4) % 65536, 262143));
      for (int i = 0; i < 210; i++) pending_items.push_back(rand_item());
    end
    wait_idle();
    if (err_count == 0 && filtered_q.size() == 0) begin
      $display("biquad_lowpass_per_sample_coeff verification clean");
    end else begin
      $display("biquad_lowpass_per_sample_coeff verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #16000000;
    $display("biquad_lowpass_per_sample_coeff verification failed");
    $finish;
  end

endmodule
